/* src/static_model_range_encoder_top_macros.svh */
// assertion macros for the range encoder
// no dependencies; included by static_model_range_encoder_top
`ifndef STATIC_MODEL_RANGE_ENCODER_TOP_MACROS_SVH
`define STATIC_MODEL_RANGE_ENCODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SMRE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SMRE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SMRE_ASSERT(label, clk, rst, prop, msg)
`define SMRE_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

/* src/smre_pkg.sv */
// shared types and constants of the range encoder
// no dependencies
package smre_pkg;

  localparam int NUM_SYM        = 256;
  localparam int COUNT_BITS_DEF = 32;
  localparam logic [31:0] TOP_LIMIT = 32'h0100_0000;
  localparam logic [31:0] BOT_LIMIT = 32'h0001_0000;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_COUNT  = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_ENCODE = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] symbol;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } code_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_C_RD, ST_C_WR, ST_B_INIT, ST_B_RD, ST_B_WR,
    ST_H_CHK, ST_H_RD, ST_H_WR, ST_E_RD0, ST_E_RD1, ST_E_RD2,
    ST_DIV, ST_M1, ST_M2, ST_M3, ST_REN, ST_FLUSH
  } state_t;

endpackage

/* src/smre_hist.sv */
// symbol histogram memory with per-entry valid bits
// depends on smre_pkg
module smre_hist
  import smre_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic [7:0]            raddr,
  output logic [COUNT_BITS-1:0] rdata,
  input  logic                  we,
  input  logic [7:0]            waddr,
  input  logic [COUNT_BITS-1:0] wdata
);

  logic [COUNT_BITS-1:0] mem [NUM_SYM];
  logic [NUM_SYM-1:0]    valid;
  logic [COUNT_BITS-1:0] rd_raw;
  logic                  rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_raw <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[raddr];
      if (clear) begin
        valid <= '0;
      end else if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld ? rd_raw : '0;

endmodule

/* src/smre_cum.sv */
// cumulative frequency table memory, 257 entries
// depends on smre_pkg
module smre_cum
  import smre_pkg::*;
(
  input  logic        clk,
  input  logic [8:0]  raddr,
  output logic [31:0] rdata,
  input  logic        we,
  input  logic [8:0]  waddr,
  input  logic [31:0] wdata
);

  logic [31:0] mem [NUM_SYM+1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/smre_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on smre_pkg; zero divisor gives an all-ones quotient
module smre_div
  import smre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [4:0]  cnt;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem, quot[31]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= divisor;
      quot <= dividend;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
      end else begin
        rem <= shifted[31:0];
      end
      quot <= {quot[30:0], ~diff[32]};
    end
  end

endmodule

/* src/static_model_range_encoder_top.sv */
// range encoder items: count, encode (through the divider), flush, and build,
// with halving passes over the table memory
// one item at a time; item_stall is high while an item is in progress
// output register lets the next item start while a byte waits on code_stall
// synchronous reset clears histogram valid bits, low = 0, range = all ones
// cumulative table is undefined until the first build
`include "static_model_range_encoder_top_macros.svh"
module static_model_range_encoder_top
  import smre_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  code_valid,
  input  logic  code_stall,
  output code_t code
);

  localparam int SW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

  state_t state, state_next;

  logic [7:0]  sym;
  logic [7:0]  bidx;
  logic [31:0] prev;
  logic [31:0] total;
  logic [31:0] low, range;
  logic [31:0] base, wid, prod;
  logic [2:0]  ncnt;

  logic [7:0]            h_raddr;
  logic [COUNT_BITS-1:0] h_rdata;
  logic                  h_we;
  logic [COUNT_BITS-1:0] h_wdata;
  logic                  h_clear;

  logic [8:0]  c_raddr;
  logic [31:0] c_rdata;
  logic        c_we;
  logic [8:0]  c_waddr;
  logic [31:0] c_wdata;

  logic        div_start, div_busy, div_done;
  logic [31:0] div_quot;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_full;

  logic [COUNT_BITS-1:0] cnt_eff;
  logic [SW-1:0]         bsum;
  logic [31:0]           bnew;
  logic [31:0]           hv;

  logic [31:0] lr_sum, rng_eff;
  logic        go1, go2, go;
  logic        out_free;
  logic        emit;

  smre_hist #(.COUNT_BITS(COUNT_BITS)) u_hist (
    .clk, .rst, .clear(h_clear), .raddr(h_raddr), .rdata(h_rdata),
    .we(h_we), .waddr(state == ST_C_WR ? sym : bidx), .wdata(h_wdata)
  );

  smre_cum u_cum (
    .clk, .raddr(c_raddr), .rdata(c_rdata), .we(c_we), .waddr(c_waddr), .wdata(c_wdata)
  );

  smre_div u_div (
    .clk, .rst, .start(div_start), .dividend(range), .divisor(total),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !code_valid || !code_stall;

  // build sum with saturation
  assign cnt_eff = (h_rdata == '0) ? COUNT_BITS'(1) : h_rdata;
  assign bsum    = SW'(prev) + SW'(cnt_eff);
  assign bnew    = (bsum > SW'(ALL_ONES)) ? ALL_ONES : bsum[31:0];

  // halving
  assign hv = ((c_rdata >> 1) <= prev) ? (prev + 32'd1) : (c_rdata >> 1);

  // renormalization test
  assign lr_sum  = low + range;
  assign go1     = (low ^ lr_sum) < TOP_LIMIT;
  assign go2     = range < BOT_LIMIT;
  assign go      = go1 || go2;
  assign rng_eff = go1 ? range : ((32'd0 - low) & (BOT_LIMIT - 32'd1));

  assign emit = ((state == ST_REN) && (ncnt != 3'd4) && go && out_free) ||
                ((state == ST_FLUSH) && out_free);

  assign mul_full = mul_a * mul_b;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          unique case (item.kind)
            KIND_COUNT:  state_next = ST_C_RD;
            KIND_BUILD:  state_next = ST_B_INIT;
            KIND_ENCODE: state_next = ST_E_RD0;
            KIND_FLUSH:  state_next = ST_FLUSH;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_C_RD:   state_next = ST_C_WR;
      ST_C_WR:   state_next = ST_IDLE;
      ST_B_INIT: state_next = ST_B_RD;
      ST_B_RD:   state_next = ST_B_WR;
      ST_B_WR:   state_next = (bidx == 8'hFF) ? ST_H_CHK : ST_B_RD;
      ST_H_CHK:  state_next = (prev >= BOT_LIMIT) ? ST_H_RD : ST_IDLE;
      ST_H_RD:   state_next = ST_H_WR;
      ST_H_WR:   state_next = (bidx == 8'hFF) ? ST_H_CHK : ST_H_RD;
      ST_E_RD0:  state_next = ST_E_RD1;
      ST_E_RD1:  state_next = ST_E_RD2;
      ST_E_RD2:  state_next = ST_DIV;
      ST_DIV:    state_next = div_done ? ST_M1 : ST_DIV;
      ST_M1:     state_next = ST_M2;
      ST_M2:     state_next = ST_M3;
      ST_M3:     state_next = ST_REN;
      ST_REN: begin
        if (ncnt == 3'd4 || !go) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free && ncnt == 3'd3) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    h_raddr   = bidx;
    h_we      = 1'b0;
    h_wdata   = h_rdata + COUNT_BITS'(1);
    h_clear   = 1'b0;
    c_raddr   = {1'b0, bidx} + 9'd1;
    c_we      = 1'b0;
    c_waddr   = {1'b0, bidx} + 9'd1;
    c_wdata   = bnew;
    div_start = 1'b0;
    mul_a     = base;
    mul_b     = div_quot;
    unique case (state)
      ST_C_RD: h_raddr = sym;
      ST_C_WR: h_we = (h_rdata != '1);
      ST_B_INIT: begin
        c_we    = 1'b1;
        c_waddr = '0;
        c_wdata = '0;
      end
      ST_B_WR: c_we = 1'b1;
      ST_H_WR: begin
        c_we    = 1'b1;
        c_wdata = hv;
      end
      ST_E_RD0: c_raddr = {1'b0, sym};
      ST_E_RD1: c_raddr = {1'b0, sym} + 9'd1;
      ST_E_RD2: div_start = 1'b1;
      ST_M2: begin
        mul_a = div_quot;
        mul_b = wid;
      end
      ST_FLUSH: h_clear = out_free && (ncnt == 3'd3);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      low        <= '0;
      range      <= ALL_ONES;
      code_valid <= 1'b0;
      ncnt       <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        code_valid <= 1'b1;
      end else if (!code_stall) begin
        code_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: ncnt <= '0;
        ST_M2:   low <= low + prod;
        ST_M3:   range <= prod;
        ST_REN: begin
          if (emit) begin
            low   <= low << 8;
            range <= rng_eff << 8;
            ncnt  <= ncnt + 3'd1;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            ncnt <= ncnt + 3'd1;
            if (ncnt == 3'd3) begin
              low   <= '0;
              range <= ALL_ONES;
            end else begin
              low <= low << 8;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      sym <= item.symbol;
    end
    unique case (state)
      ST_B_INIT: begin
        prev <= '0;
        bidx <= '0;
      end
      ST_B_WR: begin
        prev <= bnew;
        bidx <= bidx + 8'd1;
      end
      ST_H_CHK: begin
        total <= prev;
        prev  <= '0;
        bidx  <= '0;
      end
      ST_H_WR: begin
        prev <= hv;
        bidx <= bidx + 8'd1;
      end
      ST_E_RD1: base <= c_rdata;
      ST_E_RD2: wid <= c_rdata - base;
      ST_M1:    prod <= mul_full[31:0];
      ST_M2:    prod <= mul_full[31:0];
      ST_REN: begin
        if (emit) begin
          code.out_byte <= low[31:24];
          code.last     <= 1'b0;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          code.out_byte <= low[31:24];
          code.last     <= (ncnt == 3'd3);
        end
      end
      default: ;
    endcase
  end

  `SMRE_ASSERT(a_div_in_div_state, clk, rst, div_busy |-> (state == ST_DIV),
               "divider busy outside divide state")
  `SMRE_ASSERT(a_halve_increasing, clk, rst, (state == ST_H_WR) |-> (hv > prev),
               "halved table not increasing")
  `SMRE_ASSERT_NEXT(a_flush_restart, clk, rst,
                    (state == ST_FLUSH) && out_free && (ncnt == 3'd3),
                    (low == 32'd0) && (range == ALL_ONES) && code.last,
                    "flush did not restart coder")

endmodule

/* bench/range_code_checker.sv */
// predicts the encoded byte stream of the static-model range encoder and checks it
// depends on smre_pkg; instantiated by tb beside the block
module range_code_checker
  import smre_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  input  logic   item_stall,
  input  item_t  item,
  input  logic   code_valid,
  input  logic   code_stall,
  input  code_t  code,
  output int     errors,
  output int     pending
);

  logic [31:0] hist [NUM_SYM];
  logic [31:0] cum [NUM_SYM+1];
  logic [31:0] low_q;
  logic [31:0] range_q;
  code_t expected_codes [$];

  assign pending = expected_codes.size();

  task automatic add_expected(input code_t c);
    expected_codes.insert(expected_codes.size(), c);
  endtask

  task automatic build_cum();
    logic [32:0] sum;
    logic [31:0] add;
    logic [31:0] v;
    cum[0] = '0;
    for (int i = 1; i <= NUM_SYM; i++) begin
      add = (hist[i-1] == 0) ? 32'd1 : hist[i-1];
      sum = {1'b0, cum[i-1]} + {1'b0, add};
      cum[i] = sum[32] ? ALL_ONES : sum[31:0];
    end
    while (cum[NUM_SYM] >= BOT_LIMIT) begin
      for (int i = 1; i <= NUM_SYM; i++) begin
        v = cum[i] >> 1;
        if (v <= cum[i-1]) v = cum[i-1] + 32'd1;
        cum[i] = v;
      end
    end
  endtask

  task automatic predict(input item_t it);
    logic [31:0] total;
    logic [31:0] unit;
    logic [31:0] wid;
    code_t c;
    int n;
    bit go;
    case (it.kind)
      KIND_COUNT: begin
        if (hist[it.symbol] != ALL_ONES) hist[it.symbol]++;
      end
      KIND_BUILD: build_cum();
      KIND_ENCODE: begin
        total = cum[NUM_SYM];
        wid = cum[it.symbol + 1] - cum[it.symbol];
        unit = (total == 0) ? ALL_ONES : range_q / total;
        low_q = low_q + cum[it.symbol] * unit;
        range_q = unit * wid;
        n = 0;
        while (n < 4) begin
          go = 0;
          if ((low_q ^ (low_q + range_q)) < TOP_LIMIT) go = 1;
          else if (range_q < BOT_LIMIT) begin
            range_q = (32'd0 - low_q) & (BOT_LIMIT - 32'd1);
            go = 1;
          end
          if (!go) break;
          c.out_byte = low_q[31:24];
          c.last = 1'b0;
          add_expected(c);
          range_q = range_q << 8;
          low_q = low_q << 8;
          n++;
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          c.out_byte = low_q[31:24];
          c.last = (i == 3);
          add_expected(c);
          low_q = low_q << 8;
        end
        low_q = '0;
        range_q = ALL_ONES;
        for (int i = 0; i < NUM_SYM; i++) hist[i] = '0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    code_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SYM; i++) hist[i] = '0;
      low_q = '0;
      range_q = ALL_ONES;
      errors = 0;
      expected_codes.delete();
    end else begin
      if (code_valid && !code_stall) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: unexpected transaction, actual byte %h last %b",
                   $time, code.out_byte, code.last);
          errors = errors + 1;
        end else begin
          want = expected_codes.pop_front();
          if (want.out_byte !== code.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     code.out_byte);
            errors = errors + 1;
          end
          if (want.last !== code.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, code.last);
            errors = errors + 1;
          end
        end
      end
      if (item_valid && !item_stall) predict(item);
    end
  end

endmodule

/* bench/tb.sv */
// stimulus and verdict for the static-model range encoder
// depends on smre_pkg, static_model_range_encoder_top and range_code_checker
module tb;
  import smre_pkg::*;

  localparam int WATCH_LIMIT = 400000;

  logic  clk = 0;
  logic  rst = 1;
  logic  item_valid = 0;
  logic  item_stall;
  item_t item = '0;
  logic  code_valid;
  logic  code_stall = 0;
  code_t code;
  int    errors;
  int    pending;
  bit    built = 0;
  bit    quiet = 0;
  bit    hold_sink = 0;
  int    idle_cnt = 0;
  int    stall_left = 0;

  static_model_range_encoder_top dut (.*);

  range_code_checker chk (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  task automatic send(input kind_t k, input logic [7:0] s);
    item_t it;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    it.kind = k;
    it.symbol = s;
    item <= it;
    item_valid <= 1;
    do @(posedge clk); while (item_stall);
    if (k == KIND_BUILD) built = 1;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic rand_item(input int heavy);
    int r;
    r = $urandom_range(0, 99);
    if (!built || r < 40 - heavy) send(KIND_COUNT, 8'($urandom_range(0, 255)));
    else if (r < 42) send(KIND_BUILD, 8'h00);
    else if (r < 95) send(KIND_ENCODE, 8'($urandom_range(0, 255)));
    else send(KIND_FLUSH, 8'h00);
  endtask

  // sink stall: random bursts, a long hold-off, none near the end
  always @(posedge clk) begin
    if (hold_sink) begin
      code_stall <= 1;
      stall_left <= 0;
    end else if (quiet) begin
      code_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      code_stall <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      code_stall <= 1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      code_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (code_valid && !code_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCH_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, every kind, saturation-free basics
    send(KIND_COUNT, 8'h00);
    send(KIND_COUNT, 8'hFF);
    send(KIND_COUNT, 8'hFF);
    send(KIND_COUNT, 8'hA5);
    send(KIND_BUILD, 8'h5A);
    send(KIND_ENCODE, 8'h00);
    send(KIND_ENCODE, 8'hFF);
    send(KIND_ENCODE, 8'hA5);
    send(KIND_ENCODE, 8'h5A);
    send(KIND_FLUSH, 8'hFF);
    // empty histogram build, then long renormalizing runs
    send(KIND_BUILD, 8'h00);
    for (int i = 0; i < 6; i++) send(KIND_ENCODE, 8'hFF);
    send(KIND_FLUSH, 8'h00);
    // one dominant symbol
    for (int i = 0; i < 40; i++) send(KIND_COUNT, 8'h33);
    send(KIND_BUILD, 8'h00);
    send(KIND_ENCODE, 8'h33);
    send(KIND_ENCODE, 8'h34);
    item_valid <= 0;
    drain();
    // sink held off while items keep coming
    hold_sink = 1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_sink = 0;
      end
      begin
        for (int i = 0; i < 12; i++) send(KIND_ENCODE, 8'($urandom_range(0, 255)));
        item_valid <= 0;
      end
    join
    drain();
    for (int i = 0; i < 250; i++) rand_item(i % 3 == 0 ? 0 : 25);
    quiet = 1;
    for (int i = 0; i < 40; i++) rand_item(20);
    send(KIND_FLUSH, 8'h00);
    item_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
